### src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int BUTTON_COUNT_DEF  = 8;
   localparam int COUNTER_WIDTH_DEF = 16;

   localparam int CFG_WIDTH    = 16;
   localparam int BUTTON_WIDTH = 3;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET   = 16'd100;
   localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_RESET = 16'd40;

   // register select is the word address bit
   localparam logic REG_LONG_PRESS   = 1'b0;
   localparam logic REG_DOUBLE_CLICK = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PRESSED  = 2'd1,
      PH_RELEASED = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_SHORT  = 2'd0,
      EV_LONG   = 2'd1,
      EV_DOUBLE = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] long_press_ticks;
      logic [CFG_WIDTH-1:0] double_click_ticks;
   } cfg_type;

   typedef struct packed {
      event_kind_type          event_kind;
      logic [BUTTON_WIDTH-1:0] event_button;
   } result_type;

endpackage

### src/bcc_csr.sv
// ----------------------------------------------------------------------------
// bcc_csr
// Register file for the thresholds, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module bcc_csr
   import bcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CFG_WIDTH-1:0] long_ff, long_in;
   logic [CFG_WIDTH-1:0] dbl_ff, dbl_in;
   logic                 wr_en;
   logic                 reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1];

   always_comb begin
      long_in = long_ff;
      dbl_in  = dbl_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_LONG_PRESS:   long_in = csr_pwdata[CFG_WIDTH-1:0];
            REG_DOUBLE_CLICK: dbl_in  = csr_pwdata[CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff <= LONG_PRESS_RESET;
         dbl_ff  <= DOUBLE_CLICK_RESET;
      end else begin
         long_ff <= long_in;
         dbl_ff  <= dbl_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LONG_PRESS:   csr_prdata = CSR_DATA_W'(long_ff);
         REG_DOUBLE_CLICK: csr_prdata = CSR_DATA_W'(dbl_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.long_press_ticks   = long_ff;
   assign cfg.double_click_ticks = dbl_ff;

endmodule

### src/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// Sample register and the per-tick phase and counter update.
// ----------------------------------------------------------------------------
module bcc_core
   import bcc_pkg::*;
#(
   parameter int BUTTON_COUNT  = BUTTON_COUNT_DEF,
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    in_pressed,
   input  logic [BUTTON_WIDTH-1:0] in_button,
   input  logic                    out_full,
   output logic                    res_push,
   output result_type              res
);

   localparam int CMP_W = (COUNTER_WIDTH > CFG_WIDTH) ? COUNTER_WIDTH : CFG_WIDTH;
   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

   logic                     valid_ff, valid_in;
   logic                     pressed_ff;
   logic [BUTTON_WIDTH-1:0]  button_ff;
   logic                     advance;

   phase_type                phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0] press_ff, press_in;
   logic [COUNTER_WIDTH-1:0] since_ff, since_in;
   logic                     wait_ff, wait_in;
   logic [BUTTON_WIDTH-1:0]  held_ff, held_in;

   logic                     fire;
   event_kind_type           kind;
   logic                     is_short;
   logic [COUNTER_WIDTH-1:0] since_step;
   logic                     in_window;
   logic                     window_over;
   logic                     button_ok;

   assign advance  = valid_ff && !out_full;
   assign in_ready = !valid_ff || advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pressed_ff <= in_pressed;
         button_ff  <= in_button;
      end
   end

   // window counter after this tick's step, before any restart
   assign since_step = (wait_ff && (since_ff != CNT_MAX)) ? since_ff + 1'b1 : since_ff;

   assign is_short  = CMP_W'(press_ff) < CMP_W'(cfg.long_press_ticks);
   assign button_ok = 32'(button_ff) < 32'(BUTTON_COUNT);
   assign in_window = CMP_W'(since_step) < CMP_W'(cfg.double_click_ticks);

   always_comb begin
      phase_in    = phase_ff;
      press_in    = press_ff;
      since_in    = since_ff;
      wait_in     = wait_ff;
      held_in     = held_ff;
      fire        = 1'b0;
      kind        = EV_SHORT;
      window_over = 1'b0;
      if (advance) begin
         since_in = since_step;
         case (phase_ff)
            PH_PRESSED: begin
               if (press_ff != CNT_MAX) begin
                  press_in = press_ff + 1'b1;
               end
               if (!pressed_ff) begin
                  phase_in = PH_RELEASED;
               end
            end
            PH_RELEASED: begin
               phase_in = PH_IDLE;
               if (is_short) begin
                  if (wait_ff && in_window) begin
                     wait_in = 1'b0;
                     fire    = 1'b1;
                     kind    = EV_DOUBLE;
                  end else begin
                     wait_in  = 1'b1;
                     since_in = '0;
                  end
               end else begin
                  wait_in = 1'b0;
                  fire    = 1'b1;
                  kind    = EV_LONG;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (pressed_ff) begin
                  // the first click's button stays latched across a double click
                  if (wait_ff) begin
                     phase_in = PH_PRESSED;
                     press_in = '0;
                  end else if (button_ok) begin
                     held_in  = button_ff;
                     phase_in = PH_PRESSED;
                     press_in = '0;
                  end
               end
            end
         endcase
         window_over = CMP_W'(since_in) >= CMP_W'(cfg.double_click_ticks);
         // window ran out with one click pending
         if (!fire && wait_in && window_over) begin
            wait_in = 1'b0;
            fire    = 1'b1;
            kind    = EV_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         press_ff <= '0;
         since_ff <= '0;
         wait_ff  <= 1'b0;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         press_ff <= press_in;
         since_ff <= since_in;
         wait_ff  <= wait_in;
         held_ff  <= held_in;
      end
   end

   assign res_push         = fire;
   assign res.event_kind   = kind;
   assign res.event_button = held_in;

   a_fire_source: assert property (@(posedge clock) disable iff (reset)
      fire |-> (phase_ff == PH_RELEASED || wait_ff))
      else $error("event raised with no release and no pending click");

   a_fire_clears_wait: assert property (@(posedge clock) disable iff (reset)
      fire |=> !wait_ff)
      else $error("pending click survived a reported event");

   a_no_skip_pressed: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_IDLE) |=> phase_ff != PH_RELEASED)
      else $error("idle went straight to released");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_full) |=> ($stable(phase_ff) && $stable(press_ff) && valid_ff))
      else $error("state moved while the result buffer was full");

endmodule

### src/bcc_out_buf.sv
// ----------------------------------------------------------------------------
// bcc_out_buf
// Two-entry result buffer that decouples the update stage from the consumer.
// ----------------------------------------------------------------------------
module bcc_out_buf
   import bcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result pushed into a full buffer");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

endmodule

### src/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier
// Classifies polled button samples into short press, long press and double
// click events.
// ----------------------------------------------------------------------------
//
//  port group  direction  contents
//  req_*       in         one button sample per request (level, button number)
//  rsp_*       out        one event (kind in tuser, button in tdata)
//  csr_*       in/out     long press threshold, double click window
//
//  a request is taken every cycle unless the result buffer is full; its event,
//  if any, passes through the sample register, then the result buffer.
//  the sample register and the two-entry result buffer absorb rsp stalls
//  without stopping req until the buffer fills.
//  reset is synchronous; it returns the thresholds to 100 and 40 ticks.
//
module button_click_classifier
   import bcc_pkg::*;
#(
   parameter int BUTTON_COUNT  = BUTTON_COUNT_DEF,
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] pressed, [3:1] button
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [2:0] event_button
   output logic [1:0]            rsp_tuser,   // [1:0] event_kind
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   logic       res_push;
   result_type res;
   logic       buf_full;
   result_type rsp_res;

   bcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bcc_core #(
      .BUTTON_COUNT  (BUTTON_COUNT),
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pressed (req_tdata[0]),
      .in_button  (req_tdata[BUTTON_WIDTH:1]),
      .out_full   (buf_full),
      .res_push   (res_push),
      .res        (res)
   );

   bcc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   assign rsp_tdata = 8'(rsp_res.event_button);
   assign rsp_tuser = rsp_res.event_kind;

endmodule

### bench/tb_button_click_classifier.sv
// ----------------------------------------------------------------------------
// tb_button_click_classifier
// Self-checking bench for the button click classifier. Button polls are fed
// from a queue, every accepted poll runs through a local model of the
// classifier, and each event on the rsp side is compared with the oldest
// predicted one. Thresholds are changed over apb between phases.
// ----------------------------------------------------------------------------
module tb_button_click_classifier;
   import bcc_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int RUN_BUDGET   = 220;
   localparam int RUN_EVENTS   = 10;

   localparam logic [CSR_ADDR_W-1:0] ADDR_LONG_PRESS   = {REG_LONG_PRESS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_DOUBLE_CLICK = {REG_DOUBLE_CLICK, 2'b00};

   typedef struct packed {
      logic                    level;
      logic [BUTTON_WIDTH-1:0] button;
   } poll_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;   // [0] pressed, [3:1] button
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [7:0]            rsp_tdata;          // [2:0] event_button
   logic [1:0]            rsp_tuser;          // [1:0] event_kind
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   button_click_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // classifier state as the bench sees it
   cfg_type                      cfg = '{LONG_PRESS_RESET, DOUBLE_CLICK_RESET};
   phase_type                    ph          = PH_IDLE;
   logic [COUNTER_WIDTH_DEF-1:0] press_cnt   = '0;
   logic [COUNTER_WIDTH_DEF-1:0] since_cnt   = '0;
   logic                         click_pend  = 1'b0;
   logic [BUTTON_WIDTH-1:0]      latched_btn = '0;

   poll_type   pending_polls[$];
   result_type expected_events[$];
   poll_type   in_flight;
   int         req_hold     = 0;
   int         rsp_hold     = 0;
   bit         idle_on      = 1'b1;
   int         queued_polls = 0;
   int         n_accepted   = 0;
   int         n_events     = 0;
   int         kind_seen[3] = '{0, 0, 0};
   int         mismatches   = 0;
   int         cycle_count  = 0;

   function automatic logic [COUNTER_WIDTH_DEF-1:0] bump(
      input logic [COUNTER_WIDTH_DEF-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // one poll tick; returns 1 when the tick raises an event
   function automatic bit classify_poll(input poll_type p, output result_type ev);
      bit fire;
      fire = 1'b0;
      ev.event_kind = EV_SHORT;
      if (click_pend) since_cnt = bump(since_cnt);
      case (ph)
         PH_PRESSED: begin
            press_cnt = bump(press_cnt);
            if (!p.level) ph = PH_RELEASED;
         end
         PH_RELEASED: begin
            ph = PH_IDLE;
            if (press_cnt < cfg.long_press_ticks) begin
               if (click_pend && since_cnt < cfg.double_click_ticks) begin
                  click_pend    = 1'b0;
                  fire          = 1'b1;
                  ev.event_kind = EV_DOUBLE;
               end else begin
                  click_pend = 1'b1;
                  since_cnt  = '0;
               end
            end else begin
               click_pend    = 1'b0;
               fire          = 1'b1;
               ev.event_kind = EV_LONG;
            end
         end
         default: begin
            ph = PH_IDLE;
            if (p.level) begin
               // second click of a pair keeps the first button
               if (click_pend) begin
                  ph        = PH_PRESSED;
                  press_cnt = '0;
               end else if (int'(p.button) < BUTTON_COUNT_DEF) begin
                  latched_btn = p.button;
                  ph          = PH_PRESSED;
                  press_cnt   = '0;
               end
            end
         end
      endcase
      if (!fire && click_pend && since_cnt >= cfg.double_click_ticks) begin
         click_pend    = 1'b0;
         fire          = 1'b1;
         ev.event_kind = EV_SHORT;
      end
      ev.event_button = latched_btn;
      return fire;
   endfunction

   function automatic void push_poll(input logic level, input logic [BUTTON_WIDTH-1:0] btn);
      poll_type p;
      p.level  = level;
      p.button = btn;
      pending_polls.push_back(p);
      queued_polls++;
   endfunction

   // hold samples pressed, one release, then gap released samples
   task automatic add_press(input logic [BUTTON_WIDTH-1:0] btn, input int hold, input int gap);
      push_poll(1'b1, btn);
      repeat (hold - 1) push_poll(1'b1, BUTTON_WIDTH'($urandom));
      push_poll(1'b0, BUTTON_WIDTH'($urandom));
      repeat (gap) push_poll(1'b0, BUTTON_WIDTH'($urandom));
   endtask

   function automatic int reach(input logic [CFG_WIDTH-1:0] x);
      return (x > 200) ? 24 : 2 * int'(x) + 3;
   endfunction

   task automatic add_random_run(input int budget, input int min_events);
      int start_polls;
      int start_events;
      start_polls  = queued_polls;
      start_events = n_events;
      while (queued_polls - start_polls < budget || n_events - start_events < min_events) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) push_poll(1'($urandom), BUTTON_WIDTH'($urandom));
         end else begin
            add_press(BUTTON_WIDTH'($urandom), $urandom_range(1, reach(cfg.long_press_ticks)),
                      $urandom_range(1, reach(cfg.double_click_ticks)));
         end
         while (pending_polls.size() >= 8) @(negedge clock);
      end
   endtask

   task automatic settle();
      do @(negedge clock);
      while (pending_polls.size() != 0 || req_tvalid || expected_events.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CFG_WIDTH-1:0] val);
      logic [CSR_DATA_W-1:0] word;
      word = {16'($urandom), val};
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_LONG_PRESS) cfg.long_press_ticks = word[CFG_WIDTH-1:0];
      else if (addr == ADDR_DOUBLE_CLICK) cfg.double_click_ticks = word[CFG_WIDTH-1:0];
   endtask

   task automatic set_thresholds(input logic [CFG_WIDTH-1:0] long_ticks,
                                 input logic [CFG_WIDTH-1:0] window_ticks);
      csr_write(ADDR_LONG_PRESS, long_ticks);
      csr_write(ADDR_DOUBLE_CLICK, window_ticks);
   endtask

   // request driver
   always @(posedge clock) begin
      result_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (classify_poll(in_flight, ev)) begin
               expected_events.push_back(ev);
               kind_seen[int'(ev.event_kind)]++;
               n_events++;
            end
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_hold > 0) begin
               req_hold--;
               req_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
               req_hold = $urandom_range(0, 2);
               req_tvalid <= 1'b0;
            end else if (pending_polls.size() != 0) begin
               in_flight = pending_polls.pop_front();
               req_tdata  <= {4'b0000, in_flight.button, in_flight.level};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // event monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected event: kind %0d, button %0d", rsp_tuser, rsp_tdata[2:0]);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_tuser !== want.event_kind) begin
                  $error("event_kind mismatch: expected %0d, actual %0d",
                         want.event_kind, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[2:0] !== want.event_button) begin
                  $error("event_button mismatch: expected %0d, actual %0d",
                         want.event_button, rsp_tdata[2:0]);
                  mismatches++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_hold = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: a quick pair is a double click
      add_press(3'd7, 3, 2);
      add_press(3'd0, 2, 3);
      settle();

      // short after the window, then long
      set_thresholds(16'd4, 16'd6);
      add_press(3'd0, 2, 8);
      add_press(3'd5, 6, 2);
      settle();

      // zero long threshold makes every press long
      set_thresholds(16'd0, 16'd5);
      add_press(3'd2, 1, 2);
      settle();

      // zero window reports short on release, never a double
      set_thresholds(16'd5, 16'd0);
      add_press(3'd1, 1, 2);
      add_press(3'd3, 1, 1);
      add_press(3'd4, 1, 2);
      settle();

      set_thresholds(16'd100, 16'd40);
      add_random_run(RUN_BUDGET, RUN_EVENTS);
      settle();
      set_thresholds(16'd1, 16'd1);
      add_random_run(RUN_BUDGET, RUN_EVENTS);
      settle();
      set_thresholds(16'd7, 16'd5);
      add_random_run(RUN_BUDGET, RUN_EVENTS);
      settle();
      set_thresholds(16'd0, 16'd3);
      add_random_run(RUN_BUDGET, RUN_EVENTS);
      settle();
      set_thresholds(16'd20, 16'hFFFF);
      add_random_run(RUN_BUDGET, RUN_EVENTS);
      settle();
      set_thresholds(16'hFFFF, 16'd9);
      add_random_run(RUN_BUDGET, RUN_EVENTS);
      settle();

      // closing stretch at full rate on both sides
      idle_on = 1'b0;
      set_thresholds(16'd3, 16'd12);
      add_random_run(RUN_BUDGET, RUN_EVENTS);
      settle();
      repeat (8) @(posedge clock);

      $display("polls accepted: %0d, events: %0d short, %0d long, %0d double",
               n_accepted, kind_seen[int'(EV_SHORT)], kind_seen[int'(EV_LONG)],
               kind_seen[int'(EV_DOUBLE)]);
      $display("thresholds swept through 0, 1 and 65535, with stalls on both sides");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
